[rtl/core/slcfp_pkg.sv]
// ----------------------------------------------------------------------------
// slcfp_pkg
// Shared types and constants for the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
package slcfp_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [7:0] REG_SYNC_SECOND = 8'd1;

    // configuration reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

    // parse phase codes
    localparam logic [2:0] PH_SYNC1   = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_CLASS   = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_LENGTH  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CHECK   = 3'd6;

    // one result word
    typedef struct packed {
        logic [7:0] msg_class;
        logic [7:0] msg_type;
        logic [7:0] payload_length;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       checksum_good;
    } t_result;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

[rtl/core/slcfp_front.sv]
// ----------------------------------------------------------------------------
// slcfp_front
// Accepts received bytes, tracks the frame phase and checksum, and pushes
// one result word per payload byte and per checksum byte into the queue.
// ----------------------------------------------------------------------------
module slcfp_front
    import slcfp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    input  t_queue_status i_qstat,
    output logic          o_push,
    output t_result       o_push_word
);

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_class, n_class;
    logic [7:0] r_type, n_type;
    logic [7:0] r_length, n_length;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sync1, r_sync2;
    logic       accept;
    logic       emit;
    logic [7:0] count_inc;

    assign o_ready     = !i_qstat.full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign count_inc   = r_count + 8'd1;

    // phase and checksum next-state logic
    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_class  = r_class;
        n_type   = r_type;
        n_length = r_length;
        n_count  = r_count;
        emit     = 1'b0;
        o_push_word = '{msg_class: r_class, msg_type: r_type, payload_length: r_length,
                        byte_index: r_count, payload_byte: i_rx_byte,
                        frame_end: 1'b0, checksum_good: 1'b0};
        case (r_phase)
            PH_SYNC1: begin
                if (i_rx_byte == r_sync1) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                n_phase = (i_rx_byte == r_sync2) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                n_class = i_rx_byte;
                n_sum   = i_rx_byte;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_length = i_rx_byte;
                n_sum    = r_sum + i_rx_byte;
                n_count  = 8'd0;
                n_phase  = (i_rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                emit    = 1'b1;
                n_sum   = r_sum + i_rx_byte;
                n_count = count_inc;
                if (count_inc >= r_length) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                emit = 1'b1;
                o_push_word.byte_index    = 8'd0;
                o_push_word.payload_byte  = 8'd0;
                o_push_word.frame_end     = 1'b1;
                o_push_word.checksum_good = (r_sum == i_rx_byte);
                n_phase = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    assign o_push = accept && emit;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_sum    <= 8'd0;
            r_class  <= 8'd0;
            r_type   <= 8'd0;
            r_length <= 8'd0;
            r_count  <= 8'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_class  <= n_class;
            r_type   <= n_type;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

    // sync byte registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1 <= SYNC_FIRST_RST;
            r_sync2 <= SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_SYNC_FIRST) begin
                r_sync1 <= i_cfg_data;
            end
            if (i_cfg_index == REG_SYNC_SECOND) begin
                r_sync2 <= i_cfg_data;
            end
        end
    end

endmodule

[rtl/core/slcfp_queue.sv]
// ----------------------------------------------------------------------------
// slcfp_queue
// Small FIFO of result words between the parser front and the output stage.
// ----------------------------------------------------------------------------
module slcfp_queue
    import slcfp_pkg::*;
#(
    parameter int DEPTH_LOG2 = 2
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_push_word,
    input  logic          i_pop,
    output t_result       o_head,
    output t_queue_status o_status
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_result                 r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0]   r_wr_ptr;
    logic [DEPTH_LOG2-1:0]   r_rd_ptr;
    logic [DEPTH_LOG2:0]     r_count;

    assign o_status.full  = (r_count == DEPTH_LOG2'(0) + (DEPTH_LOG2+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/slcfp_back.sv]
// ----------------------------------------------------------------------------
// slcfp_back
// Output register stage: takes words from the queue and presents them on
// the result channel.
// ----------------------------------------------------------------------------
module slcfp_back
    import slcfp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_qstat,
    input  t_result       i_head,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output t_result       o_word
);

    logic    r_valid;
    t_result r_word;
    logic    load;

    // refill when the register is free or being drained
    assign load  = (!r_valid || i_ready) && !i_qstat.empty;
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= !i_qstat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_head;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[rtl/core/sync_length_checksum_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser_unit
// Two-byte-sync, length-prefixed frame parser with 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle, limited only by queue space.
// A result word is written into the queue, then loaded into the output register before it reaches the output.
// The front stalls only when the 2**QUEUE_DEPTH_LOG2-entry queue is full.
// Reset (synchronous, active low) returns to the first sync hunt, clears the
// held header and sum, and restores the sync bytes to 181 and 98.
module sync_length_checksum_frame_parser_unit
    import slcfp_pkg::*;
#(
    parameter int QUEUE_DEPTH_LOG2 = 2
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_msg_class,
    output logic [7:0] o_msg_type,
    output logic [7:0] o_payload_length,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_end,
    output logic       o_checksum_good,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_queue_status qstat;
    t_result       push_word;
    t_result       head_word;
    t_result       out_word;
    logic          push;
    logic          pop;

    // parser front
    slcfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_push_word (push_word)
    );

    // result queue
    slcfp_queue #(
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_head      (head_word),
        .o_status    (qstat)
    );

    // output stage
    slcfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head_word),
        .o_pop   (pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_word  (out_word)
    );

    assign o_msg_class      = out_word.msg_class;
    assign o_msg_type       = out_word.msg_type;
    assign o_payload_length = out_word.payload_length;
    assign o_byte_index     = out_word.byte_index;
    assign o_payload_byte   = out_word.payload_byte;
    assign o_frame_end      = out_word.frame_end;
    assign o_checksum_good  = out_word.checksum_good;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the sync/length/checksum frame parser. Received bytes
// come from a queue: a short opening list, then mostly well-formed frames with
// random headers, payloads and sums, mixed with noise and broken sync pairs.
// Sync byte values change between phases. Each output word is checked field
// by field against a local parser model, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import slcfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 45;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte   = '0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [7:0] o_msg_class;
    logic [7:0] o_msg_type;
    logic [7:0] o_payload_length;
    logic [7:0] o_byte_index;
    logic [7:0] o_payload_byte;
    logic       o_frame_end;
    logic       o_checksum_good;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data  = '0;

    sync_length_checksum_frame_parser_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_msg_class      (o_msg_class),
        .o_msg_type       (o_msg_type),
        .o_payload_length (o_payload_length),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_frame_end      (o_frame_end),
        .o_checksum_good  (o_checksum_good),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // byte stream waiting to go out, and the words it should produce
    logic [7:0] pending_bytes[$];
    t_result    expected_words[$];

    // parser model state and sync settings
    logic [7:0] sync_first    = SYNC_FIRST_RST;
    logic [7:0] sync_second   = SYNC_SECOND_RST;
    logic [2:0] hunt_phase    = PH_SYNC1;
    logic [7:0] frame_sum     = '0;
    logic [7:0] held_class    = '0;
    logic [7:0] held_type     = '0;
    logic [7:0] held_length   = '0;
    logic [7:0] payload_count = '0;

    int  errors         = 0;
    int  bytes_in       = 0;
    int  random_bytes   = 0;
    int  payload_words  = 0;
    int  good_ends      = 0;
    int  bad_ends       = 0;
    int  settings_used  = 1;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  quiet_cycles   = 0;
    bit  no_idle        = 1'b0;

    // advance the parser model by one received byte
    function automatic void parse_byte(input logic [7:0] b);
        t_result w;
        w = '0;
        case (hunt_phase)
            PH_SYNC1: begin
                if (b == sync_first) hunt_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                hunt_phase = (b == sync_second) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                held_class = b;
                frame_sum  = b;
                hunt_phase = PH_TYPE;
            end
            PH_TYPE: begin
                held_type  = b;
                frame_sum  = frame_sum + b;
                hunt_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                held_length   = b;
                frame_sum     = frame_sum + b;
                payload_count = '0;
                hunt_phase    = (b != 8'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                w.msg_class      = held_class;
                w.msg_type       = held_type;
                w.payload_length = held_length;
                w.byte_index     = payload_count;
                w.payload_byte   = b;
                expected_words.push_back(w);
                frame_sum     = frame_sum + b;
                payload_count = payload_count + 8'd1;
                if (payload_count >= held_length) hunt_phase = PH_CHECK;
            end
            PH_CHECK: begin
                w.msg_class      = held_class;
                w.msg_type       = held_type;
                w.payload_length = held_length;
                w.frame_end      = 1'b1;
                w.checksum_good  = (frame_sum == b);
                expected_words.push_back(w);
                hunt_phase = PH_SYNC1;
            end
            default: begin
                hunt_phase = PH_SYNC1;
            end
        endcase
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // payload length: mostly short, rarely long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 75) return $urandom_range(1, 6);
        if (r < 97) return $urandom_range(7, 32);
        return $urandom_range(33, 254);
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        random_bytes++;
    endfunction

    // one complete frame with the current sync bytes and a good or bad sum
    function automatic void add_frame(input int len, input bit good);
        logic [7:0] cls;
        logic [7:0] typ;
        logic [7:0] sum;
        logic [7:0] d;
        cls = 8'($urandom_range(0, 255));
        typ = 8'($urandom_range(0, 255));
        sum = cls + typ + 8'(len);
        queue_byte(sync_first);
        queue_byte(sync_second);
        queue_byte(cls);
        queue_byte(typ);
        queue_byte(8'(len));
        for (int i = 0; i < len; i++) begin
            d   = 8'($urandom_range(0, 255));
            sum = sum + d;
            queue_byte(d);
        end
        queue_byte(good ? sum : sum + 8'($urandom_range(1, 255)));
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d (word %0d)",
                 what, got, want, payload_words + good_ends + bad_ends);
        errors++;
    endtask

    // wait until the stream has drained, then give the pipeline time to settle
    task automatic settle();
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, model updated when the word is taken
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx == REG_SYNC_FIRST) sync_first = val;
        else if (idx == REG_SYNC_SECOND) sync_second = val;
        i_cfg_valid <= 1'b0;
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                parse_byte(i_rx_byte);
                bytes_in++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    i_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_bytes.size() != 0) begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= pending_bytes.pop_front();
                    gap_left  <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    flag_mismatch("unexpected word", 1, 0);
                end else begin
                    w = expected_words.pop_front();
                    if (o_msg_class != w.msg_class)
                        flag_mismatch("msg_class", o_msg_class, w.msg_class);
                    if (o_msg_type != w.msg_type)
                        flag_mismatch("msg_type", o_msg_type, w.msg_type);
                    if (o_payload_length != w.payload_length)
                        flag_mismatch("payload_length", o_payload_length, w.payload_length);
                    if (o_byte_index != w.byte_index)
                        flag_mismatch("byte_index", o_byte_index, w.byte_index);
                    if (o_payload_byte != w.payload_byte)
                        flag_mismatch("payload_byte", o_payload_byte, w.payload_byte);
                    if (o_frame_end != w.frame_end)
                        flag_mismatch("frame_end", o_frame_end, w.frame_end);
                    if (o_checksum_good != w.checksum_good)
                        flag_mismatch("checksum_good", o_checksum_good, w.checksum_good);
                end
                if (!o_frame_end) payload_words++;
                else if (o_checksum_good) good_ends++;
                else bad_ends++;
            end
            if (stall_left > 0) begin
                i_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_ready    <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [7:0] opening [25];
        logic [7:0] first_set  [6];
        logic [7:0] second_set [6];
        int r;
        int phase_start;

        opening = '{
            // noise, sync, a repeated first sync as bad second, then a lone second
            8'h00, SYNC_FIRST_RST, SYNC_FIRST_RST, SYNC_SECOND_RST,
            // zero length frame, good sum
            SYNC_FIRST_RST, SYNC_SECOND_RST, 8'hFF, 8'h00, 8'h00, 8'hFF,
            // one payload byte, bad sum
            SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h80, 8'h7F, 8'h01, 8'hFF, 8'h00,
            // two payload bytes, good sum
            SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h01, 8'h02, 8'h02, 8'hAA, 8'h55, 8'h04
        };
        first_set  = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'($urandom_range(0, 255)), SYNC_FIRST_RST};
        second_set = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'($urandom_range(0, 255)), SYNC_SECOND_RST};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening list with the reset sync values
        foreach (opening[i]) pending_bytes.push_back(opening[i]);
        settle();

        // one phase per sync setting
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_SYNC_FIRST, first_set[p]);
            write_reg(REG_SYNC_SECOND, second_set[p]);
            if (p == 2) begin
                // indexes past the register list are ignored
                write_reg(8'd2, 8'($urandom_range(0, 255)));
                write_reg(8'hFF, 8'($urandom_range(0, 255)));
            end
            settings_used++;
            no_idle = (p == 3);
            if (p == 1) add_frame(255, 1'b1);
            phase_start = random_bytes;
            while (random_bytes < phase_start + PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 78) begin
                    add_frame(pick_len(), $urandom_range(0, 9) < 7);
                end else if (r < 90) begin
                    queue_byte(8'($urandom_range(0, 255)));
                end else begin
                    queue_byte(sync_first);
                    queue_byte(sync_second ^ 8'($urandom_range(1, 255)));
                end
            end
            settle();
        end

        $display("summary: %0d bytes over %0d sync settings, extremes included",
                 bytes_in, settings_used);
        $display("summary: %0d payload words, %0d good and %0d bad frame ends, %0d errors",
                 payload_words, good_ends, bad_ends, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
